// ----- sv/pdi_fle_pkg.sv -----
package pdi_fle_pkg;

  // Operation running on the link
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_SEND  = 3'd1,
    MODE_BREAK = 3'd2,
    MODE_TURN  = 3'd3,
    MODE_RECV  = 3'd4
  } mode_t;

  // Command codes taken while idle
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_SEND  = 3'd1;
  localparam logic [2:0] CMD_BREAK = 3'd2;
  localparam logic [2:0] CMD_TURN  = 3'd3;
  localparam logic [2:0] CMD_RECV  = 3'd4;

  localparam logic [10:0] FRAME_CLOCKS = 11'd12;
  localparam logic [10:0] TURN_CLOCKS  = 11'd2;
  localparam logic [10:0] RX_EXTRA     = 11'd13;
  localparam logic [11:0] WIN_PRESET   = 12'hFFF;
  localparam logic [11:0] FRAME_MASK   = 12'hC01;
  localparam logic [11:0] FRAME_MATCH  = 12'hC00;

  // Link engine state
  typedef struct packed {
    mode_t       mode;
    logic [11:0] win;
    logic [10:0] left;
  } st_t;

  // One input request
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       line_in;
  } req_t;

  // One result
  typedef struct packed {
    logic       busy_res;
    logic       rx_timeout;
    logic [7:0] rx_byte;
    logic       rx_done;
    logic       clock_pulse;
    logic       data_drive;
    logic       data_out;
  } res_t;

endpackage

// ----- sv/pdi_frame_link_engine_unit.sv -----
// PDI link engine: each input request is one PDI clock period and yields
// exactly one result. A request is registered on entry, stepped through the
// link state machine and the result registered on exit; one request per
// cycle is sustained, and the output register and the input register stall
// together only when the result side holds tready low.
// Commands (tuser: 0 tick, 1 send frame, 2 break, 3 turnaround, 4 receive)
// are taken only while no operation runs. A frame is 12 bits LSB first with
// even parity and two stop bits; receive times out when a counter set to
// rx_idle_limit + 13 runs out. Write cfg_wdata only while the engine is idle.
module pdi_frame_link_engine_unit import pdi_fle_pkg::*; #(
  parameter int BREAK_CLOCKS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] tx_byte, [8] line_in, [15:9] zero
  input  logic [15:0] in_tdata,
  // [2:0] command
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] data_out, [1] data_drive, [2] clock_pulse, [3] rx_done,
  // [11:4] rx_byte, [12] rx_timeout, [13] busy_res, [15:14] zero
  output logic [15:0] out_tdata
);

  logic [9:0] limit_r;
  logic       s1_valid_r;
  req_t       s1_req_r;
  st_t        st_r, st_nxt;
  res_t       res;
  logic       adv;

  // Hold the receive idle limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 10'd256;
    end else if (cfg_wen) begin
      limit_r <= cfg_wdata;
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || adv;

  // Capture the input request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r.command <= in_tuser;
      s1_req_r.tx_byte <= in_tdata[7:0];
      s1_req_r.line_in <= in_tdata[8];
    end
  end

  pdi_fle_step #(
    .BREAK_CLOCKS(BREAK_CLOCKS)
  ) u_step (
    .st_cur       (st_r),
    .req          (s1_req_r),
    .rx_idle_limit(limit_r),
    .st_nxt       (st_nxt),
    .res          (res)
  );

  // Advance link state and result together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode  <= MODE_IDLE;
      st_r.win   <= WIN_PRESET;
      st_r.left  <= 11'd0;
      out_tvalid <= 1'b0;
    end else if (adv) begin
      out_tvalid <= s1_valid_r;
      if (s1_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_tdata <= {2'b00, res};
    end
  end

  // Idle always leaves the clock counter empty
  a_idle_left: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == MODE_IDLE |-> st_r.left == 11'd0)
    else $error("idle with clocks left");

  // Reported busy matches the state left behind
  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r) |=> (out_tdata[13] == (st_r.mode != MODE_IDLE)))
    else $error("busy flag disagrees with state");

  // Driving the line always comes with a clock pulse
  a_drive_clk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |-> out_tdata[2])
    else $error("line driven without clock");

  // A frame and a timeout never finish in the same period
  a_done_tmo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[3] && out_tdata[12]))
    else $error("rx done and timeout together");

endmodule

// ----- sv/pdi_fle_step.sv -----
module pdi_fle_step import pdi_fle_pkg::*; #(
  parameter int BREAK_CLOCKS = 24
) (
  input  st_t        st_cur,
  input  req_t       req,
  input  logic [9:0] rx_idle_limit,
  output st_t        st_nxt,
  output res_t       res
);

  localparam logic [10:0] BreakLeft = 11'(BREAK_CLOCKS);

  always_comb begin
    mode_t       mode;
    logic [11:0] win;
    logic [10:0] left;
    mode = st_cur.mode;
    win  = st_cur.win;
    left = st_cur.left;
    res  = '0;

    // Start an operation when idle
    if (mode == MODE_IDLE) begin
      case (req.command)
        CMD_SEND: begin
          win  = {2'b11, ^req.tx_byte, req.tx_byte, 1'b0};
          left = FRAME_CLOCKS;
          mode = MODE_SEND;
        end
        CMD_BREAK: begin
          left = BreakLeft;
          mode = MODE_BREAK;
        end
        CMD_TURN: begin
          left = TURN_CLOCKS;
          mode = MODE_TURN;
        end
        CMD_RECV: begin
          win  = WIN_PRESET;
          left = {1'b0, rx_idle_limit} + RX_EXTRA;
          mode = MODE_RECV;
        end
        default: ;
      endcase
    end

    // Run one clock of the operation
    if (mode != MODE_IDLE) begin
      res.clock_pulse = 1'b1;
      case (mode)
        MODE_SEND: begin
          res.data_drive = 1'b1;
          res.data_out   = win[0];
          win            = {1'b0, win[11:1]};
        end
        MODE_BREAK: res.data_drive = 1'b1;
        MODE_RECV:  win = {req.line_in, win[11:1]};
        default: ;
      endcase
      if (left != 11'd0) left = left - 11'd1;
      if (mode == MODE_RECV) begin
        if ((win & FRAME_MASK) == FRAME_MATCH) begin
          res.rx_done = 1'b1;
          res.rx_byte = win[8:1];
          mode        = MODE_IDLE;
          left        = 11'd0;
        end else if (left == 11'd0) begin
          res.rx_timeout = 1'b1;
          mode           = MODE_IDLE;
        end
      end else if (left == 11'd0) begin
        mode = MODE_IDLE;
      end
    end

    res.busy_res = (mode != MODE_IDLE);
    st_nxt.mode  = mode;
    st_nxt.win   = win;
    st_nxt.left  = left;
  end

endmodule
